// File: hw/rtl/lzwe_pkg.sv
package lzwe_pkg;

  localparam int MAX_WIDTH  = 12;
  localparam int DICT_DEPTH = 4096;
  localparam int ADDR_W     = $clog2(DICT_DEPTH);
  localparam int CODE_LIMIT = (DICT_DEPTH < (1 << MAX_WIDTH)) ? DICT_DEPTH : (1 << MAX_WIDTH);
  localparam int NF_W       = $clog2(CODE_LIMIT + 1);
  localparam int EP_W       = 8;
  localparam int CODE_W     = 16;
  localparam int WID_W      = 5;
  localparam int CFG_W      = 9;
  localparam int BYTE_W     = 8;
  localparam int LITERALS   = 256;

  typedef enum logic [1:0] {
    CFG_FIRST_FREE  = 2'd0,
    CFG_START_WIDTH = 2'd1,
    CFG_END_CODE    = 2'd2,
    CFG_WIDEN_CODE  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] first_free;
    logic [WID_W-1:0] start_width;
    logic [CFG_W-1:0] end_code;
    logic [CFG_W-1:0] widen_code;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              stream_end;
  } item_t;

  typedef struct packed {
    logic [EP_W-1:0]   epoch;
    logic [ADDR_W-1:0] prefix;
    logic [BYTE_W-1:0] data_byte;
    logic [ADDR_W-1:0] code;
  } dict_entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    dict_entry_t       wdata;
    logic [ADDR_W-1:0] raddr;
  } dict_req_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [WID_W-1:0]  width;
    logic              last;
  } result_t;

  function automatic logic [ADDR_W-1:0] hash_addr(logic [ADDR_W-1:0] prefix,
                                                  logic [BYTE_W-1:0] data_byte);
    return prefix ^ (ADDR_W'(data_byte) << (ADDR_W - BYTE_W));
  endfunction

endpackage

// File: hw/rtl/lzw_variable_width_encoder.sv
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   data_byte_i, stream_end_i
// out      output     out_valid_o / out_stall_i out_code_o, code_width_o, last_of_run_o
// cfg      input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Each byte after the first probes the hashed dictionary table (single read port),
// stepping on one slot per collision; the first byte of a stream needs no probe.
// Results then leave through the output register, one per cycle while out_stall_i is low.
// After reset, and after every 255th stream, a sweep over all 4096 entries clears the table;
// no item is taken meanwhile. A two-entry queue absorbs input while the back end works.
// Output stall holds the result register and halts emission.
module lzw_variable_width_encoder import lzwe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              stream_end_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CODE_W-1:0] out_code_o,
  output logic [WID_W-1:0]  code_width_o,
  output logic              last_of_run_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  cfg_t        cfg_q;
  item_t       in_item;
  item_t       q_item;
  logic        q_valid;
  logic        deq;
  dict_req_t   dict_req;
  dict_entry_t dict_rdata;
  result_t     result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_free  <= CFG_W'(258);
      cfg_q.start_width <= WID_W'(9);
      cfg_q.end_code    <= CFG_W'(257);
      cfg_q.widen_code  <= CFG_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST_FREE:  cfg_q.first_free  <= cfg_wdata_i;
        CFG_START_WIDTH: cfg_q.start_width <= cfg_wdata_i[WID_W-1:0];
        CFG_END_CODE:    cfg_q.end_code    <= cfg_wdata_i;
        CFG_WIDEN_CODE:  cfg_q.widen_code  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_item = '{data_byte: data_byte_i, stream_end: stream_end_i};

  lzwe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .item_i      (in_item),
    .in_stall_o  (in_stall_o),
    .deq_valid_o (q_valid),
    .item_o      (q_item),
    .deq_i       (deq)
  );

  lzwe_dict u_dict (
    .clk_i   (clk_i),
    .req_i   (dict_req),
    .rdata_o (dict_rdata)
  );

  lzwe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .deq_valid_i  (q_valid),
    .item_i       (q_item),
    .deq_o        (deq),
    .dict_req_o   (dict_req),
    .dict_rdata_i (dict_rdata),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result)
  );

  assign out_code_o    = result.code;
  assign code_width_o  = result.width;
  assign last_of_run_o = result.last;

endmodule

// File: hw/rtl/lzwe_queue.sv
module lzwe_queue import lzwe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  item_t item_i,
  output logic  in_stall_o,
  output logic  deq_valid_o,
  output item_t item_o,
  input  logic  deq_i
);

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;

  assign in_stall_o  = (count_q == 2'd2);
  assign deq_valid_o = (count_q != 2'd0);
  assign item_o      = slot_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = deq_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(deq_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: hw/rtl/lzwe_dict.sv
module lzwe_dict import lzwe_pkg::*; (
  input  logic        clk_i,
  input  dict_req_t   req_i,
  output dict_entry_t rdata_o
);

  dict_entry_t mem [DICT_DEPTH];
  dict_entry_t rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

endmodule

// File: hw/rtl/lzwe_back.sv
module lzwe_back import lzwe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        deq_valid_i,
  input  item_t       item_i,
  output logic        deq_o,
  output dict_req_t   dict_req_o,
  input  dict_entry_t dict_rdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output result_t     result_o
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] prefix_q, prefix_d;
  logic              pv_q, pv_d;
  logic [NF_W-1:0]   nf_q, nf_d;
  logic [WID_W-1:0]  cw_q, cw_d;
  logic [EP_W-1:0]   epoch_q, epoch_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;
  logic [ADDR_W-1:0] paddr_q, paddr_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic              clr_pend_q, clr_pend_d;
  logic [CODE_W-1:0] lcode_q [4];
  logic [CODE_W-1:0] lcode_d [4];
  logic [WID_W-1:0]  lwid_q [4];
  logic [WID_W-1:0]  lwid_d [4];
  logic [2:0]        lcnt_q, lcnt_d;
  logic [1:0]        lidx_q, lidx_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic              out_free;
  logic              hit;
  logic              empty;
  logic [NF_W-1:0]   eff_first;
  logic [WID_W-1:0]  eff_width;
  logic [ADDR_W-1:0] haddr;
  logic [ADDR_W-1:0] next_paddr;

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign hit   = (dict_rdata_i.epoch == epoch_q) && (dict_rdata_i.prefix == prefix_q) &&
                 (dict_rdata_i.data_byte == byte_q);
  assign empty = (dict_rdata_i.epoch != epoch_q);
  assign eff_first = (cfg_i.first_free < CFG_W'(LITERALS)) ? NF_W'(LITERALS)
                                                           : NF_W'(cfg_i.first_free);
  assign eff_width = (cfg_i.start_width < WID_W'(9))  ? WID_W'(9)  :
                     (cfg_i.start_width > WID_W'(16)) ? WID_W'(16) : cfg_i.start_width;
  assign haddr      = hash_addr(prefix_q, item_i.data_byte);
  assign next_paddr = (paddr_q == ADDR_W'(DICT_DEPTH - 1)) ? '0 : paddr_q + 1'b1;

  always_comb begin
    logic              end_stream;
    logic              added;
    logic              widen;
    logic [NF_W-1:0]   nf_new;
    logic [WID_W-1:0]  w;
    logic [2:0]        n;

    end_stream = 1'b0;
    added      = 1'b0;
    widen      = 1'b0;
    nf_new     = nf_q + 1'b1;
    w          = cw_q;
    n          = 3'd0;

    state_d    = state_q;
    prefix_d   = prefix_q;
    pv_d       = pv_q;
    nf_d       = nf_q;
    cw_d       = cw_q;
    epoch_d    = epoch_q;
    byte_d     = byte_q;
    last_d     = last_q;
    paddr_d    = paddr_q;
    sweep_d    = sweep_q;
    clr_pend_d = clr_pend_q;
    lcode_d    = lcode_q;
    lwid_d     = lwid_q;
    lcnt_d     = lcnt_q;
    lidx_d     = lidx_q;
    deq_o      = 1'b0;

    dict_req_o.we    = 1'b0;
    dict_req_o.waddr = paddr_q;
    dict_req_o.wdata = '0;
    dict_req_o.raddr = paddr_q;

    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      ST_CLEAR: begin
        dict_req_o.we    = 1'b1;
        dict_req_o.waddr = sweep_q;
        sweep_d          = sweep_q + 1'b1;
        if (sweep_q == ADDR_W'(DICT_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (deq_valid_i) begin
          deq_o  = 1'b1;
          byte_d = item_i.data_byte;
          last_d = item_i.stream_end;
          if (!pv_q) begin
            nf_d     = eff_first;
            cw_d     = eff_width;
            prefix_d = ADDR_W'(item_i.data_byte);
            pv_d     = 1'b1;
            if (item_i.stream_end) begin
              lcode_d[0] = CODE_W'(item_i.data_byte);
              lwid_d[0]  = eff_width;
              lcode_d[1] = CODE_W'(cfg_i.end_code);
              lwid_d[1]  = eff_width;
              n          = 3'd2;
              end_stream = 1'b1;
            end
          end else begin
            dict_req_o.raddr = haddr;
            paddr_d          = haddr;
            state_d          = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (hit) begin
          prefix_d = dict_rdata_i.code;
          if (last_q) begin
            lcode_d[0] = CODE_W'(dict_rdata_i.code);
            lwid_d[0]  = cw_q;
            lcode_d[1] = CODE_W'(cfg_i.end_code);
            lwid_d[1]  = cw_q;
            n          = 3'd2;
            end_stream = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (!empty) begin
          // collision: step to the next slot
          paddr_d          = next_paddr;
          dict_req_o.raddr = next_paddr;
        end else begin
          added = (nf_q < NF_W'(CODE_LIMIT));
          if (added) begin
            dict_req_o.we    = 1'b1;
            dict_req_o.wdata = '{epoch: epoch_q, prefix: prefix_q, data_byte: byte_q,
                                 code: nf_q[ADDR_W-1:0]};
            nf_d = nf_new;
          end
          lcode_d[0] = CODE_W'(prefix_q);
          lwid_d[0]  = cw_q;
          n          = 3'd1;
          widen = added && (cw_q < WID_W'(MAX_WIDTH)) &&
                  (32'(nf_new) >= (32'd1 << cw_q));
          if (widen) begin
            lcode_d[1] = CODE_W'(cfg_i.widen_code);
            lwid_d[1]  = cw_q;
            n          = 3'd2;
            w          = cw_q + 1'b1;
          end
          cw_d     = w;
          prefix_d = ADDR_W'(byte_q);
          if (last_q) begin
            lcode_d[n[1:0]]      = CODE_W'(byte_q);
            lwid_d[n[1:0]]       = w;
            lcode_d[n[1:0] + 1'b1] = CODE_W'(cfg_i.end_code);
            lwid_d[n[1:0] + 1'b1]  = w;
            n          = n + 3'd2;
            end_stream = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{code: lcode_q[lidx_q], width: lwid_q[lidx_q],
                    last: (3'(lidx_q) + 3'd1 == lcnt_q)};
          lidx_d = lidx_q + 1'b1;
          if (3'(lidx_q) + 3'd1 == lcnt_q) begin
            if (clr_pend_q) begin
              clr_pend_d = 1'b0;
              sweep_d    = '0;
              state_d    = ST_CLEAR;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (n != 3'd0) begin
      lcnt_d  = n;
      lidx_d  = 2'd0;
      state_d = ST_EMIT;
    end

    // retire the stream: bump the epoch, sweep the table once it wraps
    if (end_stream) begin
      prefix_d = '0;
      pv_d     = 1'b0;
      if (epoch_q == '1) begin
        epoch_d    = EP_W'(1);
        clr_pend_d = 1'b1;
      end else begin
        epoch_d = epoch_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      prefix_q    <= '0;
      pv_q        <= 1'b0;
      nf_q        <= '0;
      cw_q        <= '0;
      epoch_q     <= EP_W'(1);
      sweep_q     <= '0;
      clr_pend_q  <= 1'b0;
      lcnt_q      <= '0;
      lidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prefix_q    <= prefix_d;
      pv_q        <= pv_d;
      nf_q        <= nf_d;
      cw_q        <= cw_d;
      epoch_q     <= epoch_d;
      sweep_q     <= sweep_d;
      clr_pend_q  <= clr_pend_d;
      lcnt_q      <= lcnt_d;
      lidx_q      <= lidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    last_q  <= last_d;
    paddr_q <= paddr_d;
    lcode_q <= lcode_d;
    lwid_q  <= lwid_d;
    out_q   <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dict_req_o.we |-> (state_q == ST_CLEAR || state_q == ST_PROBE))
    else $error("dictionary written outside sweep or probe");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_o |-> state_q == ST_IDLE)
    else $error("item taken while busy");
  a_nf_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> nf_q <= NF_W'(CODE_LIMIT))
    else $error("next free code beyond limit");
  a_out_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.width >= WID_W'(9) && out_q.width <= WID_W'(16)))
    else $error("code width out of range");
`endif

endmodule
